// File: rtl/core/assert_macros.svh
// Assertion helpers for the GIF LZW core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked every clock, off during reset.
`define GLZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true.
`define GLZ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GLZ_ASSERT(lbl, prop, msg)
`define GLZ_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/glz_pkg.sv
package glz_pkg;

  localparam int unsigned CodeW    = 12;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned PixW     = 8;
  localparam int unsigned RootN    = 256;
  localparam logic [11:0] CodeLimit = 12'hfff;
  localparam logic [3:0]  MaxCodeW = 4'd12;

  // one code handed to the bit packer
  typedef struct packed {
    logic        valid;
    logic [11:0] code;
    logic [3:0]  width;
    logic        final_code;
  } code_req_t;

  // dictionary write command
  typedef struct packed {
    logic        fc_we;
    logic        ns_we;
    logic        ep_we;
    logic [11:0] addr;
    logic [11:0] link;
    logic [7:0]  pix;
  } dict_wr_t;

  function automatic logic [11:0] width_mask(input logic [3:0] w);
    logic [12:0] m;
    m = (13'd1 << w) - 13'd1;
    return m[11:0];
  endfunction

endpackage

// File: rtl/core/glz_packer.sv
module glz_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  glz_pkg::code_req_t  req_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);

  logic [19:0] acc_q, acc_d;
  logic [4:0]  n_q, n_d;
  logic        final_q, final_d;
  logic        ovld_q, ovld_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;
  logic        take_out, have_full, have_part;
  logic [19:0] code_ext;

  assign take_out  = !ovld_q || !out_stall_i;
  assign have_full = (n_q >= 5'd8);
  assign have_part = final_q && (n_q != 5'd0) && (n_q < 5'd8);
  assign ready_o   = (n_q < 5'd8) && !final_q;
  assign code_ext  = {8'd0, req_i.code & glz_pkg::width_mask(req_i.width)};

  always_comb begin
    acc_d   = acc_q;
    n_d     = n_q;
    final_d = final_q;
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (take_out) begin
      ovld_d = have_full || have_part;
      if (have_full) begin
        obyte_d = acc_q[7:0];
        acc_d   = acc_q >> 8;
        n_d     = n_q - 5'd8;
        olast_d = final_q && (n_q == 5'd8);
        if (final_q && (n_q == 5'd8)) final_d = 1'b0;
      end else if (have_part) begin
        obyte_d = acc_q[7:0];
        acc_d   = '0;
        n_d     = '0;
        olast_d = 1'b1;
        final_d = 1'b0;
      end
    end
    if (req_i.valid && ready_o) begin
      acc_d   = acc_q | (code_ext << n_q[2:0]);
      n_d     = n_q + {1'b0, req_i.width};
      final_d = req_i.final_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      n_q     <= '0;
      final_q <= 1'b0;
      ovld_q  <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      n_q     <= n_d;
      final_q <= final_d;
      ovld_q  <= ovld_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
  end

  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign last_byte_o = olast_q;

endmodule

// File: rtl/core/glz_dict.sv
module glz_dict (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [11:0]        rd_addr_i,
  input  glz_pkg::dict_wr_t  wr_i,
  input  logic               clr_roots_i,
  output logic [11:0]        fc_rdata_o,
  output logic [11:0]        ns_rdata_o,
  output logic [7:0]         ep_rdata_o
);

  logic [11:0] fc_mem [4096];
  logic [11:0] ns_mem [4096];
  logic [7:0]  ep_mem [4096];
  logic [255:0] root_vld_q;
  logic [11:0] fc_q;
  logic        vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.fc_we) fc_mem[wr_i.addr] <= wr_i.link;
    if (wr_i.ns_we) ns_mem[wr_i.addr] <= wr_i.link;
    if (wr_i.ep_we) ep_mem[wr_i.addr] <= wr_i.pix;
    fc_q       <= fc_mem[rd_addr_i];
    ns_rdata_o <= ns_mem[rd_addr_i];
    ep_rdata_o <= ep_mem[rd_addr_i];
  end

  // root first-child links read as zero until written since the last clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= '0;
      vld_q      <= 1'b0;
    end else begin
      vld_q <= (rd_addr_i[11:8] != 4'd0) || root_vld_q[rd_addr_i[7:0]];
      if (clr_roots_i) begin
        root_vld_q <= '0;
      end else if (wr_i.fc_we && (wr_i.addr[11:8] == 4'd0)) begin
        root_vld_q[wr_i.addr[7:0]] <= 1'b1;
      end
    end
  end

  assign fc_rdata_o = vld_q ? fc_q : 12'd0;

endmodule

// File: rtl/core/gif_lzw_compressor_unit.sv
// GIF LZW compressor: palette-index pixels in, packed LSB-first code bytes out.
// Input channel (in_valid_i / in_stall_o, pixel_index_i, last_pixel_i): one
// pixel per transaction. The first pixel of a stream sends a clear code; the
// transaction flagged last_pixel_i ends the stream with the prefix code, the
// end code and a flush of the partial byte, marked by last_byte_o.
// Output channel (out_valid_o / out_stall_i): one byte per transaction, held
// in an output register; a stall freezes it and backs up into the packer.
// The unit takes one pixel at a time: the input stalls until it is done with
// the last one. The dictionary walk makes one memory read per sibling visited;
// a new entry adds the S_MISS and S_LINK steps, and each extra code sent one
// more step. Bytes drain at one per cycle while out_stall_i is low, and a new
// pixel waits until the packer holds less than a byte. A byte reaches the
// output register only after the code that completes it has been written into
// the packer accumulator. The clear code enters with the first pixel's
// transaction; a miss code enters from S_MISS, after the S_FC and S_NODE walk.
// Reset: stream idle, palette_bits = 2, dictionary root links invalid (valid
// flops, no clearing pass). Config over APB, only while idle.
module gif_lzw_compressor_unit #(
  parameter int unsigned MAX_PALETTE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_index_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FC    = 3'd1;
  localparam logic [2:0] S_NODE  = 3'd2;
  localparam logic [2:0] S_MISS  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_ELAST = 3'd6;
  localparam logic [2:0] S_EEND  = 3'd7;
  localparam logic [3:0] MaxBits = 4'(MAX_PALETTE_BITS);

  logic [2:0]  state_q, state_d;
  logic [3:0]  pal_q;
  logic [7:0]  pix_q, pix_d;
  logic        last_q, last_d;
  logic [11:0] prefix_q, prefix_d;
  logic [11:0] nfc_q, nfc_d;
  logic [3:0]  cw_q, cw_d;
  logic [3:0]  sb_q, sb_d;
  logic        started_q, started_d;
  logic [11:0] node_q, node_d;
  logic        tail_q, tail_d;

  logic                pk_ready;
  glz_pkg::code_req_t  req;
  glz_pkg::dict_wr_t   wr;
  logic                clr_roots;
  logic [11:0]         rd_addr;
  logic [11:0]         fc_rdata, ns_rdata;
  logic [7:0]          ep_rdata;
  logic [3:0]          eff_bits, sb_sel;
  logic [11:0]         pix_m, clear_code, nfc_inc;
  logic [12:0]         grow_at;
  logic                in_acc;

  // APB: single register, written at any paddr with bit 2 clear, read back at every address
  assign pready = 1'b1;
  assign prdata = {28'd0, pal_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= 4'd2;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      pal_q <= pwdata[3:0];
    end
  end

  assign eff_bits   = (pal_q < 4'd2) ? 4'd2 : ((pal_q > MaxBits) ? MaxBits : pal_q);
  assign sb_sel     = started_q ? sb_q : eff_bits;
  assign pix_m      = {4'd0, pixel_index_i} & glz_pkg::width_mask(sb_sel);
  assign clear_code = 12'd1 << sb_q;
  assign nfc_inc    = nfc_q + 12'd1;
  assign grow_at    = 13'd1 << cw_q;

  assign in_stall_o = !((state_q == S_IDLE) && pk_ready);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    pix_d     = pix_q;
    last_d    = last_q;
    prefix_d  = prefix_q;
    nfc_d     = nfc_q;
    cw_d      = cw_q;
    sb_d      = sb_q;
    started_d = started_q;
    node_d    = node_q;
    tail_d    = tail_q;
    req       = '0;
    wr        = '0;
    clr_roots = 1'b0;
    rd_addr   = prefix_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pix_d  = pix_m[7:0];
          last_d = last_pixel_i;
          if (!started_q) begin
            // new stream: latch palette, reset dictionary, send clear
            sb_d       = eff_bits;
            cw_d       = eff_bits + 4'd1;
            nfc_d      = (12'd1 << eff_bits) + 12'd2;
            clr_roots  = 1'b1;
            started_d  = 1'b1;
            req.valid  = 1'b1;
            req.code   = 12'd1 << eff_bits;
            req.width  = eff_bits + 4'd1;
            prefix_d   = pix_m;
            state_d    = last_pixel_i ? S_ELAST : S_IDLE;
          end else begin
            state_d = S_FC;
          end
        end
      end
      S_FC: begin
        if (fc_rdata == 12'd0) begin
          tail_d  = 1'b0;
          state_d = S_MISS;
        end else begin
          rd_addr = fc_rdata;
          node_d  = fc_rdata;
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (ep_rdata == pix_q) begin
          prefix_d = node_q;
          state_d  = last_q ? S_ELAST : S_IDLE;
        end else if (ns_rdata == 12'd0) begin
          tail_d  = 1'b1;
          state_d = S_MISS;
        end else begin
          rd_addr = ns_rdata;
          node_d  = ns_rdata;
        end
      end
      S_MISS: begin
        if (pk_ready) begin
          req.valid = 1'b1;
          req.code  = prefix_q;
          req.width = cw_q;
          wr.fc_we  = 1'b1;
          wr.ns_we  = 1'b1;
          wr.ep_we  = 1'b1;
          wr.addr   = nfc_q;
          wr.link   = 12'd0;
          wr.pix    = pix_q;
          state_d   = S_LINK;
        end
      end
      S_LINK: begin
        // append the new entry at the chain tail found by the walk, or as the prefix's first child if it has none
        wr.fc_we = !tail_q;
        wr.ns_we = tail_q;
        wr.addr  = tail_q ? node_q : prefix_q;
        wr.link  = nfc_q;
        if ((cw_q < glz_pkg::MaxCodeW) && ({1'b0, nfc_q} == grow_at)) cw_d = cw_q + 4'd1;
        prefix_d = {4'd0, pix_q};
        if (nfc_inc == glz_pkg::CodeLimit) begin
          state_d = S_CLR;
        end else begin
          nfc_d   = nfc_inc;
          state_d = last_q ? S_ELAST : S_IDLE;
        end
      end
      S_CLR: begin
        if (pk_ready) begin
          clr_roots = 1'b1;
          req.valid = 1'b1;
          req.code  = clear_code;
          req.width = cw_q;
          cw_d      = sb_q + 4'd1;
          nfc_d     = clear_code + 12'd2;
          state_d   = last_q ? S_ELAST : S_IDLE;
        end
      end
      S_ELAST: begin
        if (pk_ready) begin
          req.valid = 1'b1;
          req.code  = prefix_q;
          req.width = cw_q;
          state_d   = S_EEND;
        end
      end
      S_EEND: begin
        if (pk_ready) begin
          req.valid      = 1'b1;
          req.code       = clear_code + 12'd1;
          req.width      = cw_q;
          req.final_code = 1'b1;
          started_d      = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      prefix_q  <= '0;
      nfc_q     <= 12'd6;
      cw_q      <= 4'd3;
      sb_q      <= 4'd2;
      started_q <= 1'b0;
      tail_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      prefix_q  <= prefix_d;
      nfc_q     <= nfc_d;
      cw_q      <= cw_d;
      sb_q      <= sb_d;
      started_q <= started_d;
      tail_q    <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    last_q <= last_d;
    node_q <= node_d;
  end

  glz_dict u_dict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .wr_i        (wr),
    .clr_roots_i (clr_roots),
    .fc_rdata_o  (fc_rdata),
    .ns_rdata_o  (ns_rdata),
    .ep_rdata_o  (ep_rdata)
  );

  glz_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (pk_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

`include "assert_macros.svh"

  `GLZ_ASSERT(a_busy_stalls, (state_q != S_IDLE) |-> in_stall_o, "input taken while busy")
  `GLZ_NEVER(a_free_code_limit, (state_q == S_IDLE) && (nfc_q == glz_pkg::CodeLimit), "free code at limit")
  `GLZ_ASSERT(a_req_states, req.valid |-> ((state_q == S_IDLE) || (state_q == S_MISS) || (state_q == S_CLR) || (state_q == S_ELAST) || (state_q == S_EEND)), "code sent from walk state")
  `GLZ_ASSERT(a_end_clears, (req.valid && req.final_code && pk_ready) |=> !started_q, "stream not closed after end code")

endmodule
